// ===== hdl/lbp_pkg.sv =====
// Shared types and constants of the 3x3 local binary pattern operator.
`default_nettype none
package lbp_pkg;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 10;
  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int CFG_W  = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic             we;
    cfg_index_t       index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic prev_mid;
    logic prev_last;
    logic low_mid;
    logic low_last;
  } flags_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] code;
    flags_t           flags;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/lbp_pix_if.sv =====
// Pixel input channel interface.
`default_nettype none
interface lbp_pix_if import lbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

// ===== hdl/lbp_res_if.sv =====
// Result output channel interface.
`default_nettype none
interface lbp_res_if import lbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] pattern_code;
  logic             frame_end;

  modport source (output valid, output out_row, output out_col, output pattern_code,
                  output frame_end, input ready);
  modport sink (input valid, input out_row, input out_col, input pattern_code,
                input frame_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/lbp_front.sv =====
// Front end: frame counters, line stores, window and pattern classification.
`default_nettype none
module lbp_front import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_wr_t           cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output entry_t            q_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam logic [WW-1:0] W_MIN = WW'(3);
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  flags_t           s1_flags_r;
  logic             s1_inner_r;
  logic [PIX_W-1:0] up_q_r;
  logic [PIX_W-1:0] mid_q_r;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] win_r [3][3];

  logic [WW-1:0]    fw_ext;
  logic [WW-1:0]    w_use;
  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;
  logic             accept;
  logic             col_end;
  logic             row_end;
  flags_t           flags;
  logic             inner;
  logic [PIX_W-1:0] code;
  logic [PIX_W-1:0] centre;

  always_comb begin
    fw_ext = WW'(fw_r);
    if (fw_ext < W_MIN) begin
      w_use = W_MIN;
    end else if (fw_ext > W_MAX) begin
      w_use = W_MAX;
    end else begin
      w_use = fw_ext;
    end
    w_last = CW'(w_use - WW'(1));
    h_last = (fh_r < FH_W'(3)) ? ROW_W'(2) : ROW_W'(fh_r - FH_W'(1));
    col_end = (col_r == w_last);
    row_end = (row_r == h_last);
    flags.prev_mid  = (row_r != '0) && (col_r != '0);
    flags.prev_last = (row_r != '0) && col_end;
    flags.low_mid   = row_end && (col_r != '0);
    flags.low_last  = row_end && col_end;
    inner = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
  end

  assign in_ready = (({1'b0, q_count} + (QCNT_W+1)'(s1_valid_r)) < (QCNT_W+1)'(QDEPTH));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= FW_RESET;
      fh_r       <= FH_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (cfg.we) begin
        unique case (cfg.index)
          REG_FRAME_WIDTH: begin
            fw_r <= cfg.data[FW_W-1:0];
          end
          REG_FRAME_HEIGHT: begin
            fh_r <= cfg.data[FH_W-1:0];
          end
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (col_end) begin
          col_r <= '0;
          row_r <= row_end ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r    <= in_pixel;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_flags_r <= flags;
      s1_inner_r <= inner;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      up_q_r           <= upper_mem[col_r];
      mid_q_r          <= lower_mem[col_r];
      lower_mem[col_r] <= in_pixel;
    end
    if (s1_valid_r) begin
      upper_mem[s1_col_r] <= mid_q_r;
    end
  end

  always_comb begin
    centre  = win_r[1][2];
    code[7] = win_r[0][1] > centre;
    code[6] = win_r[0][2] > centre;
    code[5] = up_q_r > centre;
    code[4] = mid_q_r > centre;
    code[3] = s1_px_r > centre;
    code[2] = win_r[2][2] > centre;
    code[1] = win_r[2][1] > centre;
    code[0] = win_r[1][1] > centre;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= up_q_r;
      win_r[1][2] <= mid_q_r;
      win_r[2][2] <= s1_px_r;
    end
  end

  assign q_push       = s1_valid_r;
  assign q_data.row   = s1_row_r;
  assign q_data.col   = COL_W'(s1_col_r);
  assign q_data.code  = s1_inner_r ? code : '0;
  assign q_data.flags = s1_flags_r;

endmodule
`default_nettype wire

// ===== hdl/lbp_queue.sv =====
// Short queue of classified pixel entries between front and back end.
`default_nettype none
module lbp_queue import lbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  entry_t            push_data,
  input  logic              pop,
  output entry_t            head,
  output logic              head_valid,
  output logic [QCNT_W-1:0] count
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule
`default_nettype wire

// ===== hdl/lbp_back.sv =====
// Back end: expands each queued entry into its result items.
`default_nettype none
module lbp_back import lbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  entry_t           head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic [PIX_W-1:0] pattern_code,
  output logic             frame_end
);

  entry_t           cur_r;
  flags_t           mask_r;
  flags_t           mask_nxt;
  flags_t           sel;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [PIX_W-1:0] code_r;
  logic             end_r;
  logic             can_emit;
  logic             emit;
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] col_nxt;
  logic [PIX_W-1:0] code_nxt;
  logic             end_nxt;

  always_comb begin
    can_emit = !out_valid_r || out_ready;
    emit     = (mask_r != '0) && can_emit;
    sel      = '0;
    row_nxt  = cur_r.row;
    col_nxt  = cur_r.col;
    code_nxt = '0;
    end_nxt  = 1'b0;
    if (mask_r.prev_mid) begin
      sel.prev_mid = 1'b1;
      row_nxt      = cur_r.row - ROW_W'(1);
      col_nxt      = cur_r.col - COL_W'(1);
      code_nxt     = cur_r.code;
    end else if (mask_r.prev_last) begin
      sel.prev_last = 1'b1;
      row_nxt       = cur_r.row - ROW_W'(1);
    end else if (mask_r.low_mid) begin
      sel.low_mid = 1'b1;
      col_nxt     = cur_r.col - COL_W'(1);
    end else if (mask_r.low_last) begin
      sel.low_last = 1'b1;
      end_nxt      = 1'b1;
    end
    mask_nxt      = emit ? flags_t'(mask_r & ~sel) : mask_r;
    pop           = head_valid && (mask_nxt == '0);
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= pop ? head.flags : mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (emit) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      code_r <= code_nxt;
      end_r  <= end_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row      = row_r;
  assign out_col      = col_r;
  assign pattern_code = code_r;
  assign frame_end    = end_r;

endmodule
`default_nettype wire

// ===== hdl/lbp_3x3_image_operator_unit.sv =====
// The first result item of a pixel passes the stage-one register, the queue and the entry
// register before the output register, and is held back while the output is stalled.
// Throughput: one pixel per cycle; a row-end pixel after the first row gives two results,
// the last row gives two per pixel and four at its end, and the queue then stalls the input.
// Reset: synchronous active-low reset clears counters, window, queue and output valid;
// the line stores are not cleared and need no clearing pass.
`default_nettype none
module lbp_3x3_image_operator_unit import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  lbp_pix_if.sink          in_pix,
  lbp_res_if.source        out_res,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_wr_t           cfg;
  logic              q_push;
  entry_t            q_data;
  logic              q_pop;
  entry_t            q_head;
  logic              q_head_valid;
  logic [QCNT_W-1:0] q_count;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index_t'(cfg_index);
  assign cfg.data  = cfg_wdata;

  lbp_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_pix.valid),
    .in_ready (in_pix.ready),
    .in_pixel (in_pix.pixel),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  lbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid),
    .count      (q_count)
  );

  lbp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .head_valid   (q_head_valid),
    .pop          (q_pop),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .out_row      (out_res.out_row),
    .out_col      (out_res.out_col),
    .pattern_code (out_res.pattern_code),
    .frame_end    (out_res.frame_end)
  );

endmodule
`default_nettype wire

// ===== hdl/lbp_checker.sv =====
// Port-level assertions for the operator, bound to the top level.
`default_nettype none
module lbp_checker import lbp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_row,
  input logic [COL_W-1:0] out_col,
  input logic [PIX_W-1:0] pattern_code,
  input logic             frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_row, out_col, pattern_code, frame_end}))
    else $error("Result item changed while stalled.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pattern_code != '0) |-> (out_row != '0) && (out_col != '0))
    else $error("Nonzero code on the first row or column.");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> (pattern_code == '0) && (out_row != '0))
    else $error("Frame end item is not a bottom border item.");

endmodule

bind lbp_3x3_image_operator_unit lbp_checker u_lbp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_row      (out_res.out_row),
  .out_col      (out_res.out_col),
  .pattern_code (out_res.pattern_code),
  .frame_end    (out_res.frame_end)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the 3x3 local binary pattern operator unit.
`timescale 1ns / 100ps
module tb_top;
  import lbp_pkg::*;

  localparam int MAX_W = 1024;

  typedef enum {FLOW_FULL, FLOW_SRC_SLOW, FLOW_SINK_SLOW, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] code;
    logic             last;
  } pattern_item_t;

  // Tracks the window position and line contents and queues the codes still to come.
  class lbp_code_tracker;
    logic [PIX_W-1:0] upper_line [MAX_W];
    logic [PIX_W-1:0] lower_line [MAX_W];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    pattern_item_t    pending_codes [$];
    int               errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      errors     = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = data[FW_W-1:0];
      end else begin
        height_reg = data[FH_W-1:0];
      end
      col_pos = 0;
      row_pos = 0;
    endfunction

    function logic [PIX_W-1:0] window_code();
      logic [PIX_W-1:0] m;
      m = win[1][1];
      return {win[0][0] > m, win[0][1] > m, win[0][2] > m, win[1][2] > m,
              win[2][2] > m, win[2][1] > m, win[2][0] > m, win[1][0] > m};
    endfunction

    function void push_code(int unsigned r, int unsigned c, logic [PIX_W-1:0] code,
                            logic last);
      pattern_item_t e;
      e.row  = r[ROW_W-1:0];
      e.col  = c[COL_W-1:0];
      e.code = code;
      e.last = last;
      pending_codes = {pending_codes, e};
    endfunction

    function void take_pixel(logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      r;
      int               i;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      h = height_reg;
      if (h < 3) h = 3;
      c = col_pos;
      r = row_pos;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      up  = upper_line[c];
      mid = lower_line[c];
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      upper_line[c] = mid;
      lower_line[c] = px;
      if (r >= 1) begin
        if (c >= 1) push_code(r - 1, c - 1, (r >= 2 && c >= 2) ? window_code() : '0, 1'b0);
        if (c == w - 1) push_code(r - 1, w - 1, '0, 1'b0);
      end
      if (r == h - 1) begin
        if (c >= 1) push_code(r, c - 1, '0, 1'b0);
        if (c == w - 1) push_code(r, w - 1, '0, 1'b1);
      end
      if (c == w - 1) begin
        col_pos = 0;
        row_pos = (r == h - 1) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_code(pattern_item_t got);
      pattern_item_t want;
      if (pending_codes.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result item: row %0d col %0d code %02h last %0b",
                   got.row, got.col, got.code, got.last);
        end
        return;
      end
      want = pending_codes.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.code !== want.code ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected %0d/%0d/%02h/%0b, got %0d/%0d/%02h/%0b",
                   want.row, want.col, want.code, want.last,
                   got.row, got.col, got.code, got.last);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               src_idle;
  int               sink_stall;
  lbp_code_tracker  tracker;
  pattern_item_t    seen;

  logic [PIX_W-1:0] bright_ring [9] = '{8'd255, 8'd255, 8'd255,
                                        8'd255, 8'd0,   8'd255,
                                        8'd255, 8'd255, 8'd255};
  logic [PIX_W-1:0] mixed_ring [9]  = '{8'd129, 8'd128, 8'd0,
                                        8'd130, 8'd128, 8'd255,
                                        8'd128, 8'd200, 8'd127};

  lbp_pix_if in_pix ();
  lbp_res_if out_res ();

  lbp_3x3_image_operator_unit #(.MAX_WIDTH(MAX_W)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_res.ready <= ($urandom_range(99, 0) >= sink_stall);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_pix.valid === 1'b1 && in_pix.ready === 1'b1) begin
      tracker.take_pixel(in_pix.pixel);
    end
    if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      seen.row  = out_res.out_row;
      seen.col  = out_res.out_col;
      seen.code = out_res.pattern_code;
      seen.last = out_res.frame_end;
      tracker.check_code(seen);
    end
  end

  function void set_flow(flow_t mode);
    case (mode)
      FLOW_FULL: begin
        src_idle   = 0;
        sink_stall = 0;
      end
      FLOW_SRC_SLOW: begin
        src_idle   = 88;
        sink_stall = 0;
      end
      FLOW_SINK_SLOW: begin
        src_idle   = 0;
        sink_stall = 88;
      end
      default: begin
        src_idle   = 24;
        sink_stall = 24;
      end
    endcase
  endfunction

  task write_cfg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task send_pixel(input logic [PIX_W-1:0] px);
    @(negedge clk);
    while ($urandom_range(99, 0) < src_idle) begin
      in_pix.valid <= 1'b0;
      @(negedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.pixel <= px;
    do @(posedge clk); while (in_pix.ready !== 1'b1);
  endtask

  task stop_sending();
    @(negedge clk);
    in_pix.valid <= 1'b0;
  endtask

  // A pixel in the first row causes no result item, so a fixed pause follows the drain.
  task settle();
    while (tracker.pending_codes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task run_stream(input logic [CFG_W-1:0] wval, input logic [CFG_W-1:0] hval,
                  input int unsigned npix, input bit narrow);
    logic [PIX_W-1:0] px;
    settle();
    write_cfg(REG_FRAME_WIDTH, wval);
    write_cfg(REG_FRAME_HEIGHT, hval);
    set_flow(flow_t'($urandom_range(3, 0)));
    repeat (npix) begin
      px = narrow ? PIX_W'($urandom_range(130, 126)) : PIX_W'($urandom_range(255, 0));
      send_pixel(px);
    end
    stop_sending();
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned random_items;
    int unsigned w;
    int unsigned h;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned n;
    tracker       = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_FRAME_WIDTH;
    cfg_wdata     = '0;
    in_pix.valid  = 1'b0;
    in_pix.pixel  = '0;
    out_res.ready = 1'b0;
    random_items  = 0;
    set_flow(FLOW_FULL);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Smallest frame: only the center pixel gets a code, equal neighbours leave bits clear.
    write_cfg(REG_FRAME_WIDTH, 16'h0000);
    write_cfg(REG_FRAME_HEIGHT, 16'h0001);
    foreach (bright_ring[i]) send_pixel(bright_ring[i]);
    foreach (mixed_ring[i]) send_pixel(mixed_ring[i]);
    stop_sending();

    run_stream(16'hFFFF, 16'd3, 40, 1'b0);
    run_stream(16'hF803, 16'hFFFF, 60, 1'b1);
    run_stream(16'd1024, 16'd0, 40, 1'b0);
    run_stream(16'd3, 16'd3, 18, 1'b1);

    while (random_items < 230) begin
      if ($urandom_range(9, 0) == 0) begin
        w = $urandom_range(2, 0);
      end else if ($urandom_range(7, 0) == 0) begin
        w = $urandom_range(40, 13);
      end else begin
        w = $urandom_range(12, 3);
      end
      h = ($urandom_range(5, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
      w_eff = (w < 3) ? 3 : w;
      h_eff = (h < 3) ? 3 : h;
      if ($urandom_range(99, 0) < 85) begin
        n = w_eff * h_eff * $urandom_range(2, 1);
      end else begin
        n = $urandom_range(w_eff * h_eff, 1);
      end
      run_stream(w[CFG_W-1:0], h[CFG_W-1:0], n, $urandom_range(2, 0) == 0);
      random_items += n;
    end

    settle();
    if (tracker.errors == 0 && tracker.pending_codes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
